// ===== design/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// shared constants for the curvature filter pass: field widths, register
// indexes, reset values and the divide-by-three reciprocal
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int PIX_W     = 8;
    localparam int CH_N      = 3;
    localparam int PIX_BITS  = PIX_W * CH_N;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

    // projection sums and distances
    localparam int PAIR_W = PIX_W + 1;
    localparam int TRIP_W = PIX_W + 2;
    localparam int DIST_W = PIX_W + 3;
    localparam int SEL_W  = 3;

    // floor(s / 3) = (s * 683) >> 11 for every triple sum in range
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;
    localparam int DIV3_W   = 21;

endpackage

// ===== design/cfp_if.sv =====
// ----------------------------------------------------------------------------
// cfp_in_if / cfp_out_if
// valid/ready channels carrying pixels into and filtered pixels out of the
// curvature filter pass
// ----------------------------------------------------------------------------
interface cfp_in_if;
    import cfp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             drain;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output drain, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input drain, output ready);
endinterface

interface cfp_out_if;
    import cfp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_end, output ready);
endinterface

// ===== design/curvature_filter_pass_top.sv =====
// ----------------------------------------------------------------------------
// curvature_filter_pass_top
// one pass of a stride-STRIDE curvature filter over a raster RGB stream
// ----------------------------------------------------------------------------
// usage
// - in_ch carries one pixel per request in raster order; a request with drain
//   set is a dummy that only flushes results after the last pixel of a frame
// - out_ch carries one filtered pixel per request, frame_end on the last one
// - frame_width / frame_height are written on the cfg port while idle; they are
//   latched when the first pixel of a frame arrives
// - the result of raster position p is caused by request p + STRIDE*width +
//   STRIDE, so STRIDE*width + STRIDE drain requests must follow each frame
// - a caused result passes through five register stages (line store read,
//   projection sums, distances, selection, divide) before it is valid on
//   out_ch
// - throughput is one request per cycle while out_ch does not stall; the line
//   store banks have their write and all column reads in the same cycle
// - reset clears counters and valid bits; line store contents stay unknown and
//   are never read before the current frame writes them
// - when out_ch stalls, stages fill up one by one and in_ch.ready drops only
//   once every stage holds a result; nothing is lost or repeated
// ----------------------------------------------------------------------------
module curvature_filter_pass_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int STRIDE     = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfp_pkg::CFG_W-1:0]           cfg_data,
    cfp_in_if.sink                              in_ch,
    cfp_out_if.source                           out_ch
);
    import cfp_pkg::*;

    localparam int RING = 2 * STRIDE + 2;              // rows held in the store
    localparam int SLW  = $clog2(RING);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int IW   = WW + HW + 1;
    localparam int SW   = ((WW > HW) ? WW : HW) + 3;
    localparam logic signed [SW-1:0] STRIDE_S = SW'(STRIDE);
    localparam logic signed [SW-1:0] RING_S   = SW'(RING);

    // mirrored index, border reflect
    function automatic logic signed [SW-1:0] mirror(input logic signed [SW-1:0] i,
                                                    input logic signed [SW-1:0] n);
        logic signed [SW-1:0] r;
        r = i;
        if (r < 0)
        begin
            r = -r - SW'(1);
        end
        if (r >= n)
        begin
            r = (n <<< 1) - SW'(1) - r;
        end
        if (r < 0)
        begin
            r = '0;
        end
        if (r >= n)
        begin
            r = n - SW'(1);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // configuration and frame control state
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic [WW-1:0]    cw_reg, cw_next;
    logic [HW-1:0]    ch_reg, ch_next;
    logic [IW-1:0]    total_reg, total_next;
    logic [IW-1:0]    lag_reg, lag_next;
    logic [IW-1:0]    fed_reg, fed_next;
    logic             live_reg, live_next;
    logic [WW-1:0]    in_col_reg, in_col_next;
    logic [SLW-1:0]   in_slot_reg, in_slot_next;
    logic [WW-1:0]    out_col_reg, out_col_next;
    logic [HW-1:0]    out_row_reg, out_row_next;
    logic [SLW-1:0]   out_slot_reg, out_slot_next;

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic en1, en2, en3, en4, en_out;
    logic fire;

    assign en_out      = !vo_reg || out_ch.ready;
    assign en4         = !v4_reg || en_out;
    assign en3         = !v3_reg || en4;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign in_ch.ready = en1;
    assign fire        = in_ch.valid && en1;

    // request decode
    logic [WW-1:0]        cw_clamp;
    logic [HW-1:0]        ch_clamp;
    logic [31:0]          clamp_tmp;
    logic [WW-1:0]        cw_e, in_col_e, out_col_e, in_col_inc, out_col_inc;
    logic [HW-1:0]        ch_e, out_row_e;
    logic [IW-1:0]        lag_e, fed_e;
    logic [SLW-1:0]       in_slot_e, out_slot_e;
    logic                 take, res, we, fe_e;
    logic [SLW-1:0]       wslot;
    logic [CW-1:0]        wcol;
    logic [PIX_BITS-1:0]  wdata;
    logic signed [SW-1:0] y_s, x_s, h_s, w_s, mu, md, tmp_l, tmp_r, st_u, st_d;
    logic [2:0][SLW-1:0]  slot_e;
    logic [2:0][CW-1:0]   col_e;
    logic [2:0][2:0]      byp_e;

    always_comb
    begin
        // frame size clamp
        clamp_tmp = 32'(fw_reg);
        if (clamp_tmp < 32'd2)
        begin
            clamp_tmp = 32'd2;
        end
        else if (clamp_tmp > 32'(MAX_WIDTH))
        begin
            clamp_tmp = 32'(MAX_WIDTH);
        end
        cw_clamp  = clamp_tmp[WW-1:0];
        clamp_tmp = 32'(fh_reg);
        if (clamp_tmp < 32'd2)
        begin
            clamp_tmp = 32'd2;
        end
        else if (clamp_tmp > 32'(MAX_HEIGHT))
        begin
            clamp_tmp = 32'(MAX_HEIGHT);
        end
        ch_clamp = clamp_tmp[HW-1:0];

        cw_next       = cw_reg;
        ch_next       = ch_reg;
        total_next    = total_reg;
        lag_next      = lag_reg;
        fed_next      = fed_reg;
        live_next     = live_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;

        cw_e       = cw_reg;
        ch_e       = ch_reg;
        lag_e      = lag_reg;
        fed_e      = fed_reg;
        in_col_e   = in_col_reg;
        in_slot_e  = in_slot_reg;
        out_col_e  = out_col_reg;
        out_row_e  = out_row_reg;
        out_slot_e = out_slot_reg;
        take       = 1'b0;
        res        = 1'b0;
        we         = 1'b0;

        if (fire)
        begin
            if (!in_ch.drain)
            begin
                // a pixel after a complete frame opens a new one
                if (!live_reg || fed_reg >= total_reg)
                begin
                    cw_e       = cw_clamp;
                    ch_e       = ch_clamp;
                    lag_e      = IW'(cw_clamp) * IW'(STRIDE) + IW'(STRIDE);
                    fed_e      = '0;
                    in_col_e   = '0;
                    in_slot_e  = '0;
                    out_col_e  = '0;
                    out_row_e  = '0;
                    out_slot_e = '0;
                    cw_next    = cw_clamp;
                    ch_next    = ch_clamp;
                    total_next = IW'(cw_clamp) * IW'(ch_clamp);
                    lag_next   = lag_e;
                    live_next  = 1'b1;
                end
                we         = 1'b1;
                in_col_inc = in_col_e + WW'(1);
                if (in_col_inc >= cw_e)
                begin
                    in_col_next  = '0;
                    in_slot_next = (in_slot_e == SLW'(RING - 1)) ? '0 : in_slot_e + SLW'(1);
                end
                else
                begin
                    in_col_next  = in_col_inc;
                    in_slot_next = in_slot_e;
                end
                take = 1'b1;
            end
            else if (live_reg && fed_reg >= total_reg && out_row_reg < ch_reg)
            begin
                take = 1'b1;
            end

            if (take)
            begin
                fed_next = fed_e + IW'(1);
                if (fed_e >= lag_e && out_row_e < ch_e)
                begin
                    res         = 1'b1;
                    out_col_inc = out_col_e + WW'(1);
                    if (out_col_inc >= cw_e)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_e + HW'(1);
                        out_slot_next = (out_slot_e == SLW'(RING - 1)) ? '0
                                                                       : out_slot_e + SLW'(1);
                    end
                    else
                    begin
                        out_col_next  = out_col_inc;
                        out_row_next  = out_row_e;
                        out_slot_next = out_slot_e;
                    end
                end
                else
                begin
                    out_col_next  = out_col_e;
                    out_row_next  = out_row_e;
                    out_slot_next = out_slot_e;
                end
            end
        end
        in_col_inc  = in_col_e + WW'(1);
        out_col_inc = out_col_e + WW'(1);

        fe_e  = (out_row_e == ch_e - HW'(1)) && (out_col_e == cw_e - WW'(1));
        wslot = in_slot_e;
        wcol  = in_col_e[CW-1:0];
        wdata = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

        // neighbour rows as ring slots, relative to the centre slot
        y_s  = SW'(out_row_e);
        x_s  = SW'(out_col_e);
        h_s  = SW'(ch_e);
        w_s  = SW'(cw_e);
        mu   = mirror(y_s - STRIDE_S, h_s);
        md   = mirror(y_s + STRIDE_S, h_s);
        st_u = SW'(out_slot_e) + (mu - y_s);
        if (st_u < 0)
        begin
            st_u = st_u + RING_S;
        end
        else if (st_u >= RING_S)
        begin
            st_u = st_u - RING_S;
        end
        st_d = SW'(out_slot_e) + (md - y_s);
        if (st_d < 0)
        begin
            st_d = st_d + RING_S;
        end
        else if (st_d >= RING_S)
        begin
            st_d = st_d - RING_S;
        end
        slot_e[0] = st_u[SLW-1:0];
        slot_e[1] = out_slot_e;
        slot_e[2] = st_d[SLW-1:0];

        tmp_l    = mirror(x_s - STRIDE_S, w_s);
        tmp_r    = mirror(x_s + STRIDE_S, w_s);
        col_e[0] = tmp_l[CW-1:0];
        col_e[1] = out_col_e[CW-1:0];
        col_e[2] = tmp_r[CW-1:0];

        // the request's own write lands at the same edge as its reads
        for (int t = 0; t < 3; t++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                byp_e[t][j] = we && (slot_e[t] == wslot) && (col_e[j] == wcol);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= RESET_FRAME_WIDTH;
            fh_reg       <= RESET_FRAME_HEIGHT;
            cw_reg       <= '0;
            ch_reg       <= '0;
            total_reg    <= '0;
            lag_reg      <= '0;
            fed_reg      <= '0;
            live_reg     <= 1'b0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          ;
                endcase
            end
            cw_reg       <= cw_next;
            ch_reg       <= ch_next;
            total_reg    <= total_next;
            lag_reg      <= lag_next;
            fed_reg      <= fed_next;
            live_reg     <= live_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end

    // ------------------------------------------------------------------------
    // line store: one bank per ring row, each read at the three columns
    // ------------------------------------------------------------------------
    logic [PIX_BITS-1:0] rdl_reg [RING];
    logic [PIX_BITS-1:0] rdc_reg [RING];
    logic [PIX_BITS-1:0] rdr_reg [RING];

    for (genvar b = 0; b < RING; b++)
    begin : g_bank
        logic [PIX_BITS-1:0] mem_a [MAX_WIDTH];
        logic [PIX_BITS-1:0] mem_b [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (we && wslot == SLW'(b))
            begin
                mem_a[wcol] <= wdata;
                mem_b[wcol] <= wdata;
            end
            if (en1)
            begin
                rdl_reg[b] <= mem_a[col_e[0]];
                rdc_reg[b] <= mem_a[col_e[1]];
                rdr_reg[b] <= mem_b[col_e[2]];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------------
    logic [2:0][SLW-1:0]               slot1_reg;
    logic [2:0][2:0]                   byp1_reg;
    logic [PIX_BITS-1:0]               wd1_reg;
    logic                              fe1_reg, fe2_reg, fe3_reg, fe4_reg, feo_reg;
    logic [CH_N-1:0][3:0][PAIR_W-1:0]  pair2_reg, pair3_reg, pair2_next;
    logic [CH_N-1:0][3:0][TRIP_W-1:0]  trip2_reg, trip3_reg, trip2_next;
    logic [CH_N-1:0][PIX_W-1:0]        cen2_reg, cen2_next;
    logic [CH_N-1:0][7:0][DIST_W-1:0]  dist3_reg, dist3_next;
    logic [CH_N-1:0][TRIP_W-1:0]       win4_reg, win4_next;
    logic [CH_N-1:0]                   wtrip4_reg, wtrip4_next;
    logic [CH_N-1:0][PIX_W-1:0]        res_reg, res_next;

    // stage 1: pick banks, apply bypass, form projection sums
    logic [2:0][2:0][PIX_BITS-1:0] tap;
    logic [2:0][2:0][PIX_W-1:0]    px;

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            tap[t] = '0;
            for (int b = 0; b < RING; b++)
            begin
                if (slot1_reg[t] == SLW'(b))
                begin
                    tap[t][0] = rdl_reg[b];
                    tap[t][1] = rdc_reg[b];
                    tap[t][2] = rdr_reg[b];
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                if (byp1_reg[t][j])
                begin
                    tap[t][j] = wd1_reg;
                end
            end
        end
        for (int c = 0; c < CH_N; c++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    px[t][j] = tap[t][j][c*PIX_W +: PIX_W];
                end
            end
            // px[row][col]: row 0 up, 1 centre, 2 down; col 0 left, 1 centre, 2 right
            pair2_next[c][0] = PAIR_W'(px[0][1]) + PAIR_W'(px[2][1]);
            pair2_next[c][1] = PAIR_W'(px[1][0]) + PAIR_W'(px[1][2]);
            pair2_next[c][2] = PAIR_W'(px[0][0]) + PAIR_W'(px[2][2]);
            pair2_next[c][3] = PAIR_W'(px[2][0]) + PAIR_W'(px[0][2]);
            trip2_next[c][0] = TRIP_W'(px[0][1]) + TRIP_W'(px[0][0]) + TRIP_W'(px[1][0]);
            trip2_next[c][1] = TRIP_W'(px[0][1]) + TRIP_W'(px[0][2]) + TRIP_W'(px[1][2]);
            trip2_next[c][2] = TRIP_W'(px[2][0]) + TRIP_W'(px[1][0]) + TRIP_W'(px[2][1]);
            trip2_next[c][3] = TRIP_W'(px[1][2]) + TRIP_W'(px[2][2]) + TRIP_W'(px[2][1]);
            cen2_next[c]     = px[1][1];
        end
    end

    // stage 2: distances to the centre, scaled by six
    logic [DIST_W-1:0] sc_a, sc_c;

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            sc_c = DIST_W'(cen2_reg[c]) * DIST_W'(6);
            for (int k = 0; k < 8; k++)
            begin
                if (k < 4)
                begin
                    sc_a = DIST_W'(pair2_reg[c][k]) * DIST_W'(3);
                end
                else
                begin
                    sc_a = DIST_W'(trip2_reg[c][k-4]) * DIST_W'(2);
                end
                dist3_next[c][k] = (sc_a >= sc_c) ? sc_a - sc_c : sc_c - sc_a;
            end
        end
    end

    // stage 3: nearest average, later one wins a tie
    logic [DIST_W-1:0] best_d;

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            best_d         = dist3_reg[c][0];
            win4_next[c]   = TRIP_W'(pair3_reg[c][0]);
            wtrip4_next[c] = 1'b0;
            for (int k = 1; k < 8; k++)
            begin
                if (dist3_reg[c][k] <= best_d)
                begin
                    best_d = dist3_reg[c][k];
                    if (k < 4)
                    begin
                        win4_next[c]   = TRIP_W'(pair3_reg[c][k]);
                        wtrip4_next[c] = 1'b0;
                    end
                    else
                    begin
                        win4_next[c]   = trip3_reg[c][k-4];
                        wtrip4_next[c] = 1'b1;
                    end
                end
            end
        end
    end

    // stage 4: floor of the average
    logic [DIV3_W-1:0] prod3;

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            prod3 = DIV3_W'(win4_reg[c]) * DIV3_W'(DIV3_MUL);
            if (wtrip4_reg[c])
            begin
                res_next[c] = PIX_W'(prod3 >> DIV3_SH);
            end
            else
            begin
                res_next[c] = PIX_W'(win4_reg[c] >> 1);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= fire && res;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            slot1_reg <= slot_e;
            byp1_reg  <= byp_e;
            wd1_reg   <= wdata;
            fe1_reg   <= fe_e;
        end
        if (en2)
        begin
            pair2_reg <= pair2_next;
            trip2_reg <= trip2_next;
            cen2_reg  <= cen2_next;
            fe2_reg   <= fe1_reg;
        end
        if (en3)
        begin
            pair3_reg <= pair2_reg;
            trip3_reg <= trip2_reg;
            dist3_reg <= dist3_next;
            fe3_reg   <= fe2_reg;
        end
        if (en4)
        begin
            win4_reg   <= win4_next;
            wtrip4_reg <= wtrip4_next;
            fe4_reg    <= fe3_reg;
        end
        if (en_out)
        begin
            res_reg <= res_next;
            feo_reg <= fe4_reg;
        end
    end

    assign out_ch.valid     = vo_reg;
    assign out_ch.red_out   = res_reg[0];
    assign out_ch.green_out = res_reg[1];
    assign out_ch.blue_out  = res_reg[2];
    assign out_ch.frame_end = feo_reg;

endmodule
